@@ rtl/core/sfs_pkg.sv @@
// ----------------------------------------------------------------------------
// Sprite frame sequencer package
// Shared types, register codes and widths for the sprite frame sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

	localparam int MAX_FRAMES_DEF = 64;
	localparam int DUR_W          = 24;
	localparam int ELAPSED_W      = 32;
	localparam int LOOP_W         = 17;
	localparam int DELTA_W        = 16;
	localparam int SPEED_W        = 16;
	localparam int SLOT_W         = 6;
	localparam int FRAME_OUT_W    = 6;
	localparam int FCOUNT_W       = 7;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 17;

	localparam logic [LOOP_W-1:0] LOOP_SAT = 17'h10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE      = 3'd0,
		REG_FRAME_COUNT = 3'd1,
		REG_DIRECTION   = 3'd2,
		REG_LOOP_LIMIT  = 3'd3,
		REG_SPEED       = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIR_FORWARD  = 2'd0,
		DIR_REVERSE  = 2'd1,
		DIR_PINGPONG = 2'd2,
		DIR_REV_PING = 2'd3
	} dir_t;

	typedef enum logic {
		MODE_TICK  = 1'b0,
		MODE_WRITE = 1'b1
	} mode_t;

	typedef struct packed {
		logic                mode;
		logic [DELTA_W-1:0]  delta;
		logic [SLOT_W-1:0]   frame_slot;
		logic [DUR_W-1:0]    frame_duration;
	} item_t;

	typedef struct packed {
		logic [FRAME_OUT_W-1:0] current_frame;
		logic                   is_paused;
		logic                   frame_changed;
		logic                   loop_completed;
		logic [LOOP_W-1:0]      loops_done;
	} result_t;

	typedef struct packed {
		logic                enable;
		logic [FCOUNT_W-1:0] frame_count;
		dir_t                direction;
		logic [LOOP_W-1:0]   loop_limit;
		logic [SPEED_W-1:0]  speed;
	} cfg_t;

	typedef struct packed {
		logic [ELAPSED_W-1:0] elapsed;
		logic [LOOP_W-1:0]    loop_counter;
		logic                 reversing;
		logic                 paused;
	} state_t;

	typedef struct packed {
		logic changed;
		logic looped;
	} flags_t;

endpackage

`default_nettype wire

@@ rtl/core/sfs_if.sv @@
// ----------------------------------------------------------------------------
// Sprite frame sequencer channels
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfs_item_if;
	import sfs_pkg::*;
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sfs_result_if;
	import sfs_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sfs_cfg_if;
	import sfs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sfs_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/core/sfs_cfg.sv @@
// ----------------------------------------------------------------------------
// Sprite frame sequencer registers
// Playback control registers written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_cfg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	sfs_cfg_if.sink          cfg,
	output sfs_pkg::cfg_t    regs
);

	import sfs_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.enable      <= 1'b1;
			regs_q.frame_count <= '0;
			regs_q.direction   <= DIR_FORWARD;
			regs_q.loop_limit  <= '1;
			regs_q.speed       <= SPEED_W'(256);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_ENABLE:      regs_q.enable      <= cfg.wdata[0];
				REG_FRAME_COUNT: regs_q.frame_count <= cfg.wdata[FCOUNT_W-1:0];
				REG_DIRECTION:   regs_q.direction   <= dir_t'(cfg.wdata[1:0]);
				REG_LOOP_LIMIT:  regs_q.loop_limit  <= cfg.wdata[LOOP_W-1:0];
				REG_SPEED:       regs_q.speed       <= cfg.wdata[SPEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/sfs_step.sv @@
// ----------------------------------------------------------------------------
// Sprite frame sequencer step logic
// Next elapsed time, frame index, loop count and pause state for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_step #(
	parameter int MAX_FRAMES = 64,
	parameter int IDX_W      = 6,
	parameter int CW         = 7
) (
	input  wire logic                         tick,
	input  wire sfs_pkg::cfg_t                regs,
	input  wire logic [sfs_pkg::DELTA_W-1:0]  delta,
	input  wire sfs_pkg::state_t              st,
	input  wire logic [IDX_W-1:0]             idx,
	input  wire logic [sfs_pkg::DUR_W-1:0]    dur,
	input  wire logic [sfs_pkg::DUR_W-1:0]    dur0,
	output sfs_pkg::state_t                   st_n,
	output logic      [IDX_W-1:0]             idx_n,
	output sfs_pkg::flags_t                   flg
);

	import sfs_pkg::*;

	logic [CW-1:0]                fc;
	logic [CW-1:0]                fcm1;
	logic                         stale;
	logic                         active;
	logic [IDX_W-1:0]             cur;
	logic [IDX_W-1:0]             cur_up;
	logic [IDX_W-1:0]             cur_dn;
	logic [IDX_W-1:0]             last_idx;
	logic                         wrap;
	logic                         at_last;
	logic                         fc_gt1;
	logic [DUR_W-1:0]             dsel;
	logic [DELTA_W+SPEED_W-1:0]   prod;
	logic [ELAPSED_W:0]           sum;
	logic [ELAPSED_W-1:0]         el_sat;
	logic                         counting;
	logic [LOOP_W-1:0]            lc_inc;
	logic                         pause_hit;

	assign fc = (CW'(regs.frame_count) > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES)
	                                                      : CW'(regs.frame_count);
	assign fcm1     = fc - CW'(1);
	assign stale    = CW'(idx) >= fc;
	assign active   = regs.enable && (fc != '0) && !st.paused;
	assign cur      = stale ? '0 : idx;
	assign cur_up   = cur + IDX_W'(1);
	assign cur_dn   = cur - IDX_W'(1);
	assign last_idx = fcm1[IDX_W-1:0];
	assign wrap     = (CW'(cur) + CW'(1)) == fc;
	assign at_last  = CW'(cur) >= fcm1;
	assign fc_gt1   = fc > CW'(1);
	assign dsel     = stale ? dur0 : dur;

	assign prod   = (DELTA_W+SPEED_W)'(delta) * (DELTA_W+SPEED_W)'(regs.speed);
	assign sum    = {1'b0, st.elapsed} + (ELAPSED_W+1)'(prod[DELTA_W+SPEED_W-1:8]);
	assign el_sat = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];

	assign counting  = !regs.loop_limit[LOOP_W-1];
	assign lc_inc    = (st.loop_counter < LOOP_SAT) ? st.loop_counter + LOOP_W'(1)
	                                                : st.loop_counter;
	assign pause_hit = counting && (lc_inc > {1'b0, regs.loop_limit[LOOP_W-2:0]});

	always_comb begin
		st_n  = st;
		idx_n = idx;
		flg   = '0;
		if (tick && active) begin
			idx_n = cur;
			if (regs.speed != '0) begin
				st_n.elapsed = el_sat;
				if (el_sat > ELAPSED_W'(dsel)) begin
					flg.changed  = 1'b1;
					st_n.elapsed = '0;
					unique case (regs.direction)
						DIR_FORWARD: begin
							if (wrap) begin
								flg.looped = 1'b1;
								idx_n      = pause_hit ? cur : '0;
							end else begin
								idx_n = cur_up;
							end
						end
						DIR_REVERSE: begin
							if (cur == '0) begin
								flg.looped = 1'b1;
								idx_n      = pause_hit ? '0 : last_idx;
							end else begin
								idx_n = cur_dn;
							end
						end
						DIR_PINGPONG: begin
							if (!st.reversing) begin
								if (at_last) begin
									st_n.reversing = 1'b1;
									idx_n          = fc_gt1 ? cur_dn : cur;
								end else begin
									idx_n = cur_up;
								end
							end else if (cur == '0) begin
								st_n.reversing = 1'b0;
								flg.looped     = 1'b1;
								idx_n          = (!pause_hit && fc_gt1) ? cur_up : cur;
							end else begin
								idx_n = cur_dn;
							end
						end
						DIR_REV_PING: begin
							if (st.reversing) begin
								if (cur == '0) begin
									st_n.reversing = 1'b0;
									idx_n          = fc_gt1 ? cur_up : cur;
								end else begin
									idx_n = cur_dn;
								end
							end else if (at_last) begin
								st_n.reversing = 1'b1;
								flg.looped     = 1'b1;
								idx_n          = (!pause_hit && fc_gt1) ? cur_dn : cur;
							end else begin
								idx_n = cur_up;
							end
						end
					endcase
					if (flg.looped && counting) begin
						st_n.loop_counter = lc_inc;
						st_n.paused       = pause_hit;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/sprite_frame_sequencer.sv @@
// Each result is registered; a stalled result holds the next item in
// the input register. Throughput: one item per cycle while results are taken;
// the tick logic and duration RAM read-ahead finish while the item is in it.
// Reset: arst_n clears playback state and restores register defaults at once;
// frame durations are undefined until written.
// ----------------------------------------------------------------------------
// Sprite frame sequencer
// Steps one sprite animation through its frames on time ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_frame_sequencer #(
	parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sfs_item_if.sink   item,
	sfs_result_if.source result,
	sfs_cfg_if.sink    cfg
);

	import sfs_pkg::*;

	localparam int IDX_W  = $clog2(MAX_FRAMES);
	localparam int FC_W   = $clog2(MAX_FRAMES + 1);
	localparam int CW     = (FC_W > FCOUNT_W) ? FC_W : FCOUNT_W;
	localparam int SLOT_XW = IDX_W + SLOT_W;

	cfg_t               regs;
	logic               valid_s1;
	item_t              item_s1;
	logic               out_valid_q;
	result_t            res_q;
	state_t             st_q;
	logic [IDX_W-1:0]   idx_q;
	logic               byp_q;
	logic [DUR_W-1:0]   byp_data_q;
	logic [DUR_W-1:0]   dur0_q;

	logic               adv;
	state_t             st_n;
	logic [IDX_W-1:0]   idx_n;
	flags_t             flg;
	logic [SLOT_XW-1:0] slot_x;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [IDX_W-1:0]   rd_addr;
	logic [DUR_W-1:0]   ram_rdata;
	logic [DUR_W-1:0]   dur_cur;
	logic [IDX_W+FRAME_OUT_W-1:0] idx_x;

	sfs_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	assign adv          = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready   = !valid_s1 || adv;
	assign result.valid = out_valid_q;
	assign result.data  = res_q;

	assign slot_x  = {{IDX_W{1'b0}}, item_s1.frame_slot};
	assign wr_en   = adv && (item_s1.mode == MODE_WRITE) &&
	                 (slot_x < SLOT_XW'(MAX_FRAMES));
	assign wr_addr = slot_x[IDX_W-1:0];
	assign rd_addr = adv ? idx_n : idx_q;
	assign dur_cur = byp_q ? byp_data_q : ram_rdata;

	sfs_ram #(
		.WIDTH (DUR_W),
		.DEPTH (MAX_FRAMES)
	) u_dur_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (item_s1.frame_duration),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	sfs_step #(
		.MAX_FRAMES (MAX_FRAMES),
		.IDX_W      (IDX_W),
		.CW         (CW)
	) u_step (
		.tick  (item_s1.mode == MODE_TICK),
		.regs  (regs),
		.delta (item_s1.delta),
		.st    (st_q),
		.idx   (idx_q),
		.dur   (dur_cur),
		.dur0  (dur0_q),
		.st_n  (st_n),
		.idx_n (idx_n),
		.flg   (flg)
	);

	assign idx_x = {{FRAME_OUT_W{1'b0}}, idx_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			st_q        <= '0;
			idx_q       <= '0;
			byp_q       <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				st_q        <= st_n;
				idx_q       <= idx_n;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready) begin
			item_s1 <= item.data;
		end
		if (adv) begin
			res_q.current_frame  <= idx_x[FRAME_OUT_W-1:0];
			res_q.is_paused      <= st_n.paused;
			res_q.frame_changed  <= flg.changed;
			res_q.loop_completed <= flg.looped;
			res_q.loops_done     <= st_n.loop_counter;
		end
		byp_data_q <= item_s1.frame_duration;
		if (wr_en && (wr_addr == '0)) begin
			dur0_q <= item_s1.frame_duration;
		end
	end

`ifndef ASSERT_OFF
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("stalled transaction left the input register");

	a_clear_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		adv && flg.changed |=> st_q.elapsed == '0)
		else $error("elapsed time not cleared on frame change");

	a_pause_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.paused |=> st_q.paused)
		else $error("pause released without reset");

	a_loop_change: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.loop_completed |-> result.data.frame_changed)
		else $error("loop completed without frame change");
`endif

endmodule

`default_nettype wire

@@ tb/tb_sprite_frame_sequencer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sprite frame sequencer testbench
// Loads the frame duration table, then drives tick and duration-write
// transactions under several register settings and idling patterns. Each
// accepted transaction is run through a local model of the sequencer, and
// every result is checked field by field against the oldest expected status.
// ----------------------------------------------------------------------------

module tb_sprite_frame_sequencer;
	import sfs_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_STALL  = 300;
	localparam int SETTLE      = 4;

	logic clk;
	logic arst_n;

	sfs_item_if   item_bus ();
	sfs_result_if result_bus ();
	sfs_cfg_if    cfg_bus ();

	sprite_frame_sequencer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	// Model state and register copy
	logic [DUR_W-1:0]     dur_table [MAX_FRAMES_DEF];
	logic [ELAPSED_W-1:0] elapsed_time = '0;
	int                   frame_pos;
	logic [LOOP_W-1:0]    loop_count = '0;
	bit                   reversing;
	bit                   playback_paused;
	cfg_t                 cfg_shadow;

	item_t   queued_items [$];
	result_t expected_status [$];
	result_t oldest_status;

	int  send_idle_pct;
	int  recv_idle_pct;
	bit  sender_hold;
	int  stall_requests;
	int  stalls_served;
	int  hold_cycles;
	int  cycle_count;
	int  error_count;
	int  items_accepted;
	int  ticks_accepted;
	int  writes_accepted;
	int  reg_writes;
	int  frame_steps_seen;
	int  loop_wraps_seen;
	bit  last_paused;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic bit close_loop();
		int lim;
		lim = cfg_shadow.loop_limit[LOOP_W-1] ?
			int'(cfg_shadow.loop_limit[LOOP_W-2:0]) - 65536 : int'(cfg_shadow.loop_limit);
		if (lim < 0)
			return 1'b0;
		if (loop_count < LOOP_SAT)
			loop_count = loop_count + LOOP_W'(1);
		if (int'(loop_count) > lim)
			playback_paused = 1'b1;
		return playback_paused;
	endfunction

	function automatic void advance_tick(input logic [DELTA_W-1:0] delta,
			output bit changed, output bit looped);
		int fc;
		int old_pos;
		logic [ELAPSED_W-1:0] product;
		logic [ELAPSED_W-1:0] add;
		changed = 1'b0;
		looped  = 1'b0;
		fc = (cfg_shadow.frame_count > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF :
			int'(cfg_shadow.frame_count);
		if (!cfg_shadow.enable || fc == 0 || playback_paused)
			return;
		if (frame_pos >= fc)
			frame_pos = 0;
		if (cfg_shadow.speed == 0)
			return;
		product = ELAPSED_W'(delta) * ELAPSED_W'(cfg_shadow.speed);
		add = product >> 8;
		elapsed_time = (elapsed_time > 32'hFFFF_FFFF - add) ? 32'hFFFF_FFFF : elapsed_time + add;
		if (elapsed_time <= ELAPSED_W'(dur_table[frame_pos]))
			return;
		changed = 1'b1;
		elapsed_time = '0;
		old_pos = frame_pos;
		case (cfg_shadow.direction)
			DIR_FORWARD: begin
				frame_pos = (frame_pos + 1 == fc) ? 0 : frame_pos + 1;
				if (frame_pos == 0) begin
					looped = 1'b1;
					if (close_loop())
						frame_pos = old_pos;
				end
			end
			DIR_REVERSE: begin
				if (frame_pos == 0) begin
					frame_pos = fc - 1;
					looped = 1'b1;
					if (close_loop())
						frame_pos = 0;
				end else begin
					frame_pos = frame_pos - 1;
				end
			end
			DIR_PINGPONG: begin
				if (!reversing) begin
					if (frame_pos >= fc - 1) begin
						reversing = 1'b1;
						if (fc > 1)
							frame_pos = frame_pos - 1;
					end else begin
						frame_pos = frame_pos + 1;
					end
				end else if (frame_pos == 0) begin
					reversing = 1'b0;
					looped = 1'b1;
					if (!close_loop() && fc > 1)
						frame_pos = frame_pos + 1;
				end else begin
					frame_pos = frame_pos - 1;
				end
			end
			default: begin
				if (reversing) begin
					if (frame_pos == 0) begin
						reversing = 1'b0;
						if (fc > 1)
							frame_pos = frame_pos + 1;
					end else begin
						frame_pos = frame_pos - 1;
					end
				end else if (frame_pos >= fc - 1) begin
					reversing = 1'b1;
					looped = 1'b1;
					if (!close_loop() && fc > 1)
						frame_pos = frame_pos - 1;
				end else begin
					frame_pos = frame_pos + 1;
				end
			end
		endcase
	endfunction

	function automatic result_t predict_frame_step(item_t it);
		result_t r;
		bit changed;
		bit looped;
		changed = 1'b0;
		looped  = 1'b0;
		if (it.mode == MODE_WRITE)
			dur_table[it.frame_slot] = it.frame_duration;
		else
			advance_tick(it.delta, changed, looped);
		r.current_frame  = frame_pos[FRAME_OUT_W-1:0];
		r.is_paused      = playback_paused;
		r.frame_changed  = changed;
		r.loop_completed = looped;
		r.loops_done     = loop_count;
		return r;
	endfunction

	function automatic logic [DELTA_W-1:0] rand_delta();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return DELTA_W'($urandom_range(0, 120));
		if (r < 90)
			return DELTA_W'($urandom_range(0, 600));
		return DELTA_W'($urandom_range(0, 65535));
	endfunction

	function automatic logic [DUR_W-1:0] rand_duration();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return DUR_W'($urandom_range(0, 200));
		if (r < 95)
			return DUR_W'($urandom_range(0, 5000));
		return DUR_W'($urandom_range(0, 24'hFF_FFFF));
	endfunction

	task automatic queue_tick(logic [DELTA_W-1:0] delta);
		item_t it;
		it = '0;
		it.mode  = MODE_TICK;
		it.delta = delta;
		it.frame_slot = SLOT_W'($urandom_range(0, 63));
		it.frame_duration = DUR_W'($urandom_range(0, 24'hFF_FFFF));
		queued_items.push_back(it);
	endtask

	task automatic queue_write(int slot, int dur);
		item_t it;
		it = '0;
		it.mode = MODE_WRITE;
		it.delta = DELTA_W'($urandom_range(0, 65535));
		it.frame_slot = SLOT_W'(slot);
		it.frame_duration = DUR_W'(dur);
		queued_items.push_back(it);
	endtask

	task automatic write_reg(reg_idx_t idx, int val);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.wdata <= CFG_DATA_W'(val);
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		reg_writes++;
		case (idx)
			REG_ENABLE:      cfg_shadow.enable = val[0];
			REG_FRAME_COUNT: cfg_shadow.frame_count = val[FCOUNT_W-1:0];
			REG_DIRECTION:   cfg_shadow.direction = dir_t'(val[1:0]);
			REG_LOOP_LIMIT:  cfg_shadow.loop_limit = val[LOOP_W-1:0];
			REG_SPEED:       cfg_shadow.speed = val[SPEED_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (queued_items.size() != 0 || item_bus.valid || expected_status.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic program_random_setup();
		int r;
		int v;
		write_reg(REG_ENABLE, ($urandom_range(99) < 90) ? 1 : 0);
		r = $urandom_range(99);
		if (r < 60)
			v = $urandom_range(1, 8);
		else if (r < 80)
			v = $urandom_range(9, 64);
		else if (r < 88)
			v = MAX_FRAMES_DEF;
		else if (r < 93)
			v = 0;
		else
			v = $urandom_range(65, 127);
		write_reg(REG_FRAME_COUNT, v);
		write_reg(REG_DIRECTION, $urandom_range(0, 3));
		// keep the limit well ahead of the count so playback never pauses here
		r = $urandom_range(9);
		if (r < 5)
			v = 'h1FFFF;
		else if (r < 8)
			v = 'h0FFFF;
		else
			v = int'(loop_count) + 400 + int'($urandom_range(0, 200));
		write_reg(REG_LOOP_LIMIT, v);
		r = $urandom_range(99);
		if (r < 40)
			v = 256;
		else if (r < 60)
			v = $urandom_range(1, 600);
		else if (r < 75)
			v = $urandom_range(0, 65535);
		else if (r < 85)
			v = 0;
		else if (r < 92)
			v = 'hFFFF;
		else
			v = $urandom_range(1, 64);
		write_reg(REG_SPEED, v);
	endtask

	task automatic run_random_phase(int send_pct, int recv_pct, int n_items, bit pressure);
		int done;
		int batch;
		int sub;
		int start_acc;
		done = 0;
		sub = 0;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		while (done < n_items) begin
			program_random_setup();
			@(negedge clk);
			batch = $urandom_range(40, 70);
			repeat (batch) begin
				if ($urandom_range(99) < 15)
					queue_write($urandom_range(0, 63), rand_duration());
				else
					queue_tick(rand_delta());
			end
			if (pressure && sub == 0)
				stall_requests++;
			if (pressure && sub == 1) begin
				start_acc = items_accepted;
				while (items_accepted < start_acc + batch / 2)
					@(negedge clk);
				sender_hold = 1'b1;
				while (item_bus.valid || expected_status.size() != 0)
					@(negedge clk);
				sender_hold = 1'b0;
			end
			wait_idle();
			done += batch;
			sub++;
		end
	endtask

	task automatic check_field(string field, int want, int got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	// Driver: offer queued transactions, predict each one as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_bus.valid <= 1'b0;
		end else begin
			if (item_bus.valid && item_bus.ready) begin
				expected_status.push_back(predict_frame_step(item_bus.data));
				items_accepted++;
				if (item_bus.data.mode == MODE_WRITE)
					writes_accepted++;
				else
					ticks_accepted++;
			end
			if (!item_bus.valid || item_bus.ready) begin
				if (queued_items.size() != 0 && !sender_hold &&
						$urandom_range(99) >= send_idle_pct) begin
					item_bus.data  <= queued_items.pop_front();
					item_bus.valid <= 1'b1;
				end else begin
					item_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cycles   <= 0;
			stalls_served <= 0;
		end else if (stalls_served != stall_requests) begin
			hold_cycles   <= LONG_STALL;
			stalls_served <= stall_requests;
		end else if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	// Monitor: check each result transaction against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				if (expected_status.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result, expected none, actual %h", $time,
						result_bus.data);
				end else begin
					oldest_status = expected_status.pop_front();
					check_field("current_frame", int'(oldest_status.current_frame),
						int'(result_bus.data.current_frame));
					check_field("is_paused", int'(oldest_status.is_paused),
						int'(result_bus.data.is_paused));
					check_field("frame_changed", int'(oldest_status.frame_changed),
						int'(result_bus.data.frame_changed));
					check_field("loop_completed", int'(oldest_status.loop_completed),
						int'(result_bus.data.loop_completed));
					check_field("loops_done", int'(oldest_status.loops_done),
						int'(result_bus.data.loops_done));
					frame_steps_seen += int'(result_bus.data.frame_changed);
					loop_wraps_seen  += int'(result_bus.data.loop_completed);
					last_paused = result_bus.data.is_paused;
				end
			end
			result_bus.ready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		cfg_bus.valid    <= 1'b0;
		cfg_bus.index    <= REG_ENABLE;
		cfg_bus.wdata    <= '0;
		arst_n = 1'b0;
		reg_writes = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		sender_hold = 1'b0;
		stall_requests = 0;
		cfg_shadow.enable      = 1'b1;
		cfg_shadow.frame_count = '0;
		cfg_shadow.direction   = DIR_FORWARD;
		cfg_shadow.loop_limit  = 17'h1FFFF;
		cfg_shadow.speed       = 16'd256;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// nothing plays with no frames in use
		queue_tick(16'h0000);
		queue_tick(16'hFFFF);
		// load every duration before any frame is played
		for (int i = 0; i < MAX_FRAMES_DEF; i++) begin
			if (i == MAX_FRAMES_DEF - 2)
				queue_write(i, 'h00_0000);
			else if (i == MAX_FRAMES_DEF - 1)
				queue_write(i, 'hFF_FFFF);
			else
				queue_write(i, $urandom_range(1, 40));
		end
		wait_idle();

		write_reg(REG_ENABLE, 1);
		write_reg(REG_FRAME_COUNT, 4);
		write_reg(REG_DIRECTION, int'(DIR_FORWARD));
		write_reg(REG_LOOP_LIMIT, 'h1FFFF);
		write_reg(REG_SPEED, 256);
		@(negedge clk);
		queue_tick(16'h0000);
		queue_tick(16'h0001);
		repeat (5) queue_tick(16'hFFFF);
		wait_idle();

		// stale index with speed frozen, then playback disabled
		write_reg(REG_SPEED, 0);
		write_reg(REG_FRAME_COUNT, 1);
		@(negedge clk);
		queue_tick(16'd100);
		wait_idle();
		write_reg(REG_ENABLE, 0);
		@(negedge clk);
		queue_tick(16'hFFFF);
		wait_idle();

		// frame count beyond the table, reverse wrap onto the longest frame
		write_reg(REG_ENABLE, 1);
		write_reg(REG_SPEED, 'hFFFF);
		write_reg(REG_FRAME_COUNT, 127);
		write_reg(REG_DIRECTION, int'(DIR_REVERSE));
		@(negedge clk);
		repeat (3) queue_tick(16'hFFFF);
		wait_idle();

		// single frame turns
		write_reg(REG_SPEED, 256);
		write_reg(REG_FRAME_COUNT, 1);
		write_reg(REG_DIRECTION, int'(DIR_PINGPONG));
		@(negedge clk);
		repeat (3) queue_tick(16'hFFFF);
		wait_idle();

		write_reg(REG_FRAME_COUNT, 5);
		write_reg(REG_DIRECTION, int'(DIR_REV_PING));
		@(negedge clk);
		repeat (6) queue_tick(16'hFFFF);
		wait_idle();

		run_random_phase(0, 0, 200, 1'b1);
		run_random_phase(58, 0, 200, 1'b0);
		run_random_phase(0, 58, 200, 1'b0);
		run_random_phase(15, 15, 200, 1'b0);

		// the pause is permanent, so bring it about only at the end
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_ENABLE, 1);
		write_reg(REG_FRAME_COUNT, $urandom_range(1, 6));
		write_reg(REG_DIRECTION, $urandom_range(0, 3));
		write_reg(REG_SPEED, 256);
		write_reg(REG_LOOP_LIMIT, $urandom_range(0, 1) ? 0 : int'(loop_count));
		@(negedge clk);
		for (int i = 0; i < 6; i++)
			queue_write(i, $urandom_range(0, 30));
		repeat (30) queue_tick(16'hFFFF);
		wait_idle();

		$display("covered %0d transactions (%0d ticks, %0d duration writes), %0d register writes",
			items_accepted, ticks_accepted, writes_accepted, reg_writes);
		$display("saw %0d frame steps and %0d loop wraps, final loop count %0d, paused %0d",
			frame_steps_seen, loop_wraps_seen, loop_count, last_paused);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", error_count);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/sfs_pkg.sv
rtl/core/sfs_if.sv
rtl/core/sfs_ram.sv
rtl/core/sfs_cfg.sv
rtl/core/sfs_step.sv
rtl/core/sprite_frame_sequencer.sv
tb/tb_sprite_frame_sequencer.sv
